FILE: design/tcc_pkg.sv
// Shared constants, command/status types and helpers for the text console cursor engine.
`default_nettype none

package tcc_pkg;

   // screen geometry
   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELLS      = COLUMNS * ROWS;
   localparam int COPY_CELLS = (ROWS - 1) * COLUMNS;

   // field widths
   localparam int OP_W    = 3;
   localparam int CHAR_W  = 8;
   localparam int ATTR_W  = 8;
   localparam int COORD_W = 8;
   localparam int CELL_W  = 16;
   localparam int COL_W   = 7;
   localparam int ROW_W   = 5;
   localparam int POS_W   = 11;
   localparam int ADDR_W  = $clog2(CELLS);
   localparam int CNT_W   = $clog2(CELLS + 1);

   // operation codes
   localparam logic [OP_W-1:0] OP_PUT_CHAR = 3'd0;
   localparam logic [OP_W-1:0] OP_SET_CUR  = 3'd1;
   localparam logic [OP_W-1:0] OP_WR_CELL  = 3'd2;
   localparam logic [OP_W-1:0] OP_CLEAR    = 3'd3;
   localparam logic [OP_W-1:0] OP_RD_CELL  = 3'd4;

   // character codes with special handling
   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

   localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;
   localparam logic [CELL_W-1:0] RESET_CELL = {RESET_ATTR, CH_SPACE};

   // controller to datapath
   typedef struct packed {
      logic capture;      // take the request word
      logic execute;      // apply the captured item
      logic sweep_start;  // begin a pass over the cell memory
      logic sweep_init;   // pass writes the power-on blank
      logic load_rsp;     // load the response register
   } tcc_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_scroll;
      logic need_clear;
      logic sweep_done;
   } tcc_stat_type;

   // linear cell address of a row and column
   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                   input logic [COL_W-1:0] c);
      logic [ADDR_W-1:0] rr;
      logic [ADDR_W-1:0] cc;
      rr = ADDR_W'(r);
      cc = ADDR_W'(c);
      return ADDR_W'(rr * ADDR_W'(COLUMNS)) + cc;
   endfunction

endpackage

`default_nettype wire

FILE: design/tcc_channels.sv
// Request and response channel interfaces of the text console cursor engine.
`default_nettype none

interface tcc_req_if;
   logic                         valid;
   logic                         ready;
   logic [tcc_pkg::OP_W-1:0]     operation;
   logic [tcc_pkg::CHAR_W-1:0]   char_code;
   logic [tcc_pkg::COORD_W-1:0]  column;
   logic [tcc_pkg::COORD_W-1:0]  line;
   logic [tcc_pkg::ATTR_W-1:0]   cell_attribute;

   modport source (output valid, operation, char_code, column, line, cell_attribute,
                   input ready);
   modport sink   (input valid, operation, char_code, column, line, cell_attribute,
                   output ready);
endinterface

interface tcc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [tcc_pkg::CELL_W-1:0]   cell_data;
   logic [tcc_pkg::COL_W-1:0]    cursor_column;
   logic [tcc_pkg::ROW_W-1:0]    cursor_line;
   logic [tcc_pkg::POS_W-1:0]    cursor_position;
   logic                         range_error;

   modport source (output valid, cell_data, cursor_column, cursor_line, cursor_position,
                   range_error, input ready);
   modport sink   (input valid, cell_data, cursor_column, cursor_line, cursor_position,
                   range_error, output ready);
endinterface

`default_nettype wire

FILE: design/text_console_cursor_engine.sv
// Top level of the text console cursor engine.
// The engine keeps an 80x25 text screen of 16-bit cells (attribute high byte, character
// low byte) in one single-port-write cell memory and a cursor, and answers every request
// word with one response word that reports the cursor. Put char, set cursor, write cell
// and read cell each pass through an execute and a respond state; the next request is
// taken in the respond state once the response register is free. A put char that runs
// past the bottom row scrolls, and clear screen blanks the screen: both walk the whole
// cell memory one cell per cycle through its single write port. After reset the engine
// writes every cell to a grey-on-black space before it accepts the first request; csr
// writes are taken at any time meanwhile.
`default_nettype none

module text_console_cursor_engine (
   input  wire logic                       clock,
   input  wire logic                       reset,
   tcc_req_if.sink                         req_ch,
   tcc_rsp_if.source                       rsp_ch,
   input  wire logic                       csr_wen,
   input  wire logic [tcc_pkg::ATTR_W-1:0] csr_wdata
);

   tcc_pkg::tcc_cmd_type  cmd;
   tcc_pkg::tcc_stat_type stat;

   // sequencing
   tcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // cursor, memory and response word
   tcc_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_wen             (csr_wen),
      .csr_wdata           (csr_wdata),
      .req_operation       (req_ch.operation),
      .req_char_code       (req_ch.char_code),
      .req_column          (req_ch.column),
      .req_line            (req_ch.line),
      .req_cell_attribute  (req_ch.cell_attribute),
      .cmd                 (cmd),
      .stat                (stat),
      .rsp_cell_data       (rsp_ch.cell_data),
      .rsp_cursor_column   (rsp_ch.cursor_column),
      .rsp_cursor_line     (rsp_ch.cursor_line),
      .rsp_cursor_position (rsp_ch.cursor_position),
      .rsp_range_error     (rsp_ch.range_error)
   );

endmodule

`default_nettype wire

FILE: design/tcc_ctrl.sv
// Control state machine: request handshake, memory pass sequencing, response register valid.
`default_nettype none

module tcc_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire tcc_pkg::tcc_stat_type stat,
   output tcc_pkg::tcc_cmd_type       cmd
);

   localparam logic [2:0] ST_BOOT  = 3'd0;
   localparam logic [2:0] ST_INIT  = 3'd1;
   localparam logic [2:0] ST_IDLE  = 3'd2;
   localparam logic [2:0] ST_EXEC  = 3'd3;
   localparam logic [2:0] ST_SWEEP = 3'd4;
   localparam logic [2:0] ST_RESP  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_BOOT: begin
            cmd.sweep_start = 1'b1;
            cmd.sweep_init  = 1'b1;
            state_in        = ST_INIT;
         end
         ST_INIT: begin
            if (stat.sweep_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.execute = 1'b1;
            if (stat.need_scroll || stat.need_clear) begin
               cmd.sweep_start = 1'b1;
               state_in        = ST_SWEEP;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_SWEEP: begin
            if (stat.sweep_done) state_in = ST_RESP;
         end
         ST_RESP: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               req_ready    = 1'b1;
               if (req_valid) begin
                  cmd.capture = 1'b1;
                  state_in    = ST_EXEC;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_BOOT;
         end
      endcase
   end

   // response valid: set on load, cleared when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_BOOT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/tcc_datapath.sv
// Datapath: request capture, cursor update, cell memory, memory pass engine, response word.
`default_nettype none

module tcc_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wen,
   input  wire logic [tcc_pkg::ATTR_W-1:0]    csr_wdata,
   input  wire logic [tcc_pkg::OP_W-1:0]      req_operation,
   input  wire logic [tcc_pkg::CHAR_W-1:0]    req_char_code,
   input  wire logic [tcc_pkg::COORD_W-1:0]   req_column,
   input  wire logic [tcc_pkg::COORD_W-1:0]   req_line,
   input  wire logic [tcc_pkg::ATTR_W-1:0]    req_cell_attribute,
   input  wire tcc_pkg::tcc_cmd_type          cmd,
   output tcc_pkg::tcc_stat_type              stat,
   output logic [tcc_pkg::CELL_W-1:0]         rsp_cell_data,
   output logic [tcc_pkg::COL_W-1:0]          rsp_cursor_column,
   output logic [tcc_pkg::ROW_W-1:0]          rsp_cursor_line,
   output logic [tcc_pkg::POS_W-1:0]          rsp_cursor_position,
   output logic                               rsp_range_error
);

   localparam int NCOL_W = tcc_pkg::COL_W + 1;
   localparam int NROW_W = tcc_pkg::ROW_W + 1;

   // text attribute register
   logic [tcc_pkg::ATTR_W-1:0] attr_ff, attr_in;

   // captured request word
   logic [tcc_pkg::OP_W-1:0]    op_ff, op_in;
   logic [tcc_pkg::CHAR_W-1:0]  ch_ff, ch_in;
   logic [tcc_pkg::COORD_W-1:0] col_ff, col_in;
   logic [tcc_pkg::COORD_W-1:0] line_ff, line_in;
   logic [tcc_pkg::ATTR_W-1:0]  cattr_ff, cattr_in;

   // cursor
   logic [tcc_pkg::COL_W-1:0] cur_col_ff, cur_col_in;
   logic [tcc_pkg::ROW_W-1:0] cur_row_ff, cur_row_in;

   // memory pass engine
   logic                        sw_run_ff, sw_run_in;
   logic [tcc_pkg::CNT_W-1:0]   sw_ptr_ff, sw_ptr_in;
   logic                        sw_copy_ff, sw_copy_in;
   logic                        sw_init_ff, sw_init_in;
   logic                        st_vld_ff, st_vld_in;
   logic [tcc_pkg::ADDR_W-1:0]  st_addr_ff, st_addr_in;
   logic                        st_copy_ff, st_copy_in;

   // cell memory
   logic [tcc_pkg::CELL_W-1:0]  mem [tcc_pkg::CELLS];
   logic [tcc_pkg::CELL_W-1:0]  rd_data_ff;
   logic                        mem_we, mem_re;
   logic [tcc_pkg::ADDR_W-1:0]  mem_wa, mem_ra;
   logic [tcc_pkg::CELL_W-1:0]  mem_wd;

   // response word
   logic [tcc_pkg::CELL_W-1:0]  data_ff, data_in;
   logic [tcc_pkg::COL_W-1:0]   rcol_ff, rcol_in;
   logic [tcc_pkg::ROW_W-1:0]   rrow_ff, rrow_in;
   logic [tcc_pkg::POS_W-1:0]   rpos_ff, rpos_in;
   logic                        rerr_ff, rerr_in;

   // decode
   logic is_put, is_set, is_wr, is_clr, is_rd, on_screen;
   logic [NCOL_W-1:0]           cur_col8, pc_col;
   logic [NROW_W-1:0]           pc_row;
   logic                        pc_we, pc_scroll;
   logic [tcc_pkg::CHAR_W-1:0]  pc_char;
   logic [tcc_pkg::COL_W-1:0]   pc_wcol;
   logic [tcc_pkg::ADDR_W-1:0]  ex_addr;
   logic [tcc_pkg::CELL_W-1:0]  ex_data;
   logic                        ex_we, ex_re, sw_re;

   assign is_put = (op_ff == tcc_pkg::OP_PUT_CHAR);
   assign is_set = (op_ff == tcc_pkg::OP_SET_CUR);
   assign is_wr  = (op_ff == tcc_pkg::OP_WR_CELL);
   assign is_clr = (op_ff == tcc_pkg::OP_CLEAR);
   assign is_rd  = (op_ff == tcc_pkg::OP_RD_CELL);
   assign on_screen = (col_ff < tcc_pkg::COORD_W'(tcc_pkg::COLUMNS)) &&
                      (line_ff < tcc_pkg::COORD_W'(tcc_pkg::ROWS));
   assign cur_col8 = {1'b0, cur_col_ff};

   // put char: control codes, advance, wrap
   always_comb begin
      pc_col  = cur_col8;
      pc_row  = {1'b0, cur_row_ff};
      pc_we   = 1'b0;
      pc_char = ch_ff;
      pc_wcol = cur_col_ff;
      case (ch_ff)
         tcc_pkg::CH_NEWLINE: begin
            pc_col = '0;
            pc_row = pc_row + NROW_W'(1);
         end
         tcc_pkg::CH_RETURN: begin
            pc_col = '0;
         end
         tcc_pkg::CH_BACKSPACE: begin
            if (cur_col_ff != '0) begin
               pc_col  = cur_col8 - NCOL_W'(1);
               pc_we   = 1'b1;
               pc_char = tcc_pkg::CH_SPACE;
               pc_wcol = cur_col_ff - tcc_pkg::COL_W'(1);
            end
         end
         tcc_pkg::CH_TAB: begin
            pc_col = (cur_col8 + NCOL_W'(4)) & ~NCOL_W'(3);
         end
         default: begin
            pc_we  = 1'b1;
            pc_col = cur_col8 + NCOL_W'(1);
         end
      endcase
      if (pc_col >= NCOL_W'(tcc_pkg::COLUMNS)) begin
         pc_col = '0;
         pc_row = pc_row + NROW_W'(1);
      end
      pc_scroll = (pc_row >= NROW_W'(tcc_pkg::ROWS));
   end

   assign stat.need_scroll = is_put && pc_scroll;
   assign stat.need_clear  = is_clr;
   assign stat.sweep_done  = st_vld_ff && (st_addr_ff == tcc_pkg::ADDR_W'(tcc_pkg::CELLS - 1));

   // memory access of the item itself
   assign ex_addr = is_put ? tcc_pkg::cell_addr(cur_row_ff, pc_wcol)
                           : tcc_pkg::cell_addr(line_ff[tcc_pkg::ROW_W-1:0],
                                                col_ff[tcc_pkg::COL_W-1:0]);
   assign ex_data = is_put ? {attr_ff, pc_char} : {cattr_ff, ch_ff};
   assign ex_we   = cmd.execute && ((is_put && pc_we) || (is_wr && on_screen));
   assign ex_re   = cmd.execute && is_rd && on_screen;

   // memory pass: read one row ahead, write one stage behind
   assign sw_re = sw_run_ff && sw_copy_ff &&
                  (sw_ptr_ff < tcc_pkg::CNT_W'(tcc_pkg::COPY_CELLS));

   assign mem_re = sw_re || ex_re;
   assign mem_ra = sw_run_ff ? tcc_pkg::ADDR_W'(sw_ptr_ff + tcc_pkg::CNT_W'(tcc_pkg::COLUMNS))
                             : ex_addr;
   assign mem_we = st_vld_ff || ex_we;
   assign mem_wa = st_vld_ff ? st_addr_ff : ex_addr;
   always_comb begin
      if (!st_vld_ff)      mem_wd = ex_data;
      else if (st_copy_ff) mem_wd = rd_data_ff;
      else if (sw_init_ff) mem_wd = tcc_pkg::RESET_CELL;
      else                 mem_wd = {attr_ff, tcc_pkg::CH_SPACE};
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      if (mem_re) rd_data_ff <= mem[mem_ra];
   end

   // pass engine next state
   always_comb begin
      sw_run_in  = sw_run_ff;
      sw_ptr_in  = sw_ptr_ff;
      sw_copy_in = sw_copy_ff;
      sw_init_in = sw_init_ff;
      if (cmd.sweep_start) begin
         sw_run_in  = 1'b1;
         sw_ptr_in  = '0;
         sw_copy_in = !cmd.sweep_init && stat.need_scroll;
         sw_init_in = cmd.sweep_init;
      end else if (sw_run_ff) begin
         sw_ptr_in = sw_ptr_ff + tcc_pkg::CNT_W'(1);
         if (sw_ptr_ff == tcc_pkg::CNT_W'(tcc_pkg::CELLS - 1)) sw_run_in = 1'b0;
      end
      st_vld_in  = sw_run_ff;
      st_addr_in = tcc_pkg::ADDR_W'(sw_ptr_ff);
      st_copy_in = sw_re;
   end

   // config, capture and cursor
   always_comb begin
      attr_in  = csr_wen ? csr_wdata : attr_ff;
      op_in    = op_ff;
      ch_in    = ch_ff;
      col_in   = col_ff;
      line_in  = line_ff;
      cattr_in = cattr_ff;
      if (cmd.capture) begin
         op_in    = req_operation;
         ch_in    = req_char_code;
         col_in   = req_column;
         line_in  = req_line;
         cattr_in = req_cell_attribute;
      end
      cur_col_in = cur_col_ff;
      cur_row_in = cur_row_ff;
      if (cmd.execute) begin
         if (is_put) begin
            cur_col_in = tcc_pkg::COL_W'(pc_col);
            cur_row_in = pc_scroll ? tcc_pkg::ROW_W'(tcc_pkg::ROWS - 1)
                                   : tcc_pkg::ROW_W'(pc_row);
         end else if (is_set && on_screen) begin
            cur_col_in = col_ff[tcc_pkg::COL_W-1:0];
            cur_row_in = line_ff[tcc_pkg::ROW_W-1:0];
         end else if (is_clr) begin
            cur_col_in = '0;
            cur_row_in = '0;
         end
      end
   end

   // response word
   always_comb begin
      data_in = data_ff;
      rcol_in = rcol_ff;
      rrow_in = rrow_ff;
      rpos_in = rpos_ff;
      rerr_in = rerr_ff;
      if (cmd.load_rsp) begin
         data_in = (is_rd && on_screen) ? rd_data_ff : '0;
         rcol_in = cur_col_ff;
         rrow_in = cur_row_ff;
         rpos_in = tcc_pkg::POS_W'(tcc_pkg::cell_addr(cur_row_ff, cur_col_ff));
         rerr_in = !on_screen && (is_set || is_wr || is_rd);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff    <= tcc_pkg::RESET_ATTR;
         cur_col_ff <= '0;
         cur_row_ff <= '0;
         sw_run_ff  <= 1'b0;
         sw_ptr_ff  <= '0;
         sw_copy_ff <= 1'b0;
         sw_init_ff <= 1'b0;
         st_vld_ff  <= 1'b0;
      end else begin
         attr_ff    <= attr_in;
         cur_col_ff <= cur_col_in;
         cur_row_ff <= cur_row_in;
         sw_run_ff  <= sw_run_in;
         sw_ptr_ff  <= sw_ptr_in;
         sw_copy_ff <= sw_copy_in;
         sw_init_ff <= sw_init_in;
         st_vld_ff  <= st_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      ch_ff      <= ch_in;
      col_ff     <= col_in;
      line_ff    <= line_in;
      cattr_ff   <= cattr_in;
      st_addr_ff <= st_addr_in;
      st_copy_ff <= st_copy_in;
      data_ff    <= data_in;
      rcol_ff    <= rcol_in;
      rrow_ff    <= rrow_in;
      rpos_ff    <= rpos_in;
      rerr_ff    <= rerr_in;
   end

   assign rsp_cell_data       = data_ff;
   assign rsp_cursor_column   = rcol_ff;
   assign rsp_cursor_line     = rrow_ff;
   assign rsp_cursor_position = rpos_ff;
   assign rsp_range_error     = rerr_ff;

endmodule

`default_nettype wire

FILE: design/tcc_checker.sv
// Port-level checker for the text console cursor engine and its bind.
`default_nettype none

module tcc_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [tcc_pkg::CELL_W-1:0]  rsp_cell_data,
   input wire logic [tcc_pkg::COL_W-1:0]   rsp_cursor_column,
   input wire logic [tcc_pkg::ROW_W-1:0]   rsp_cursor_line,
   input wire logic [tcc_pkg::POS_W-1:0]   rsp_cursor_position,
   input wire logic                        rsp_range_error
);

   logic [tcc_pkg::POS_W-1:0] exp_pos;

   assign exp_pos = tcc_pkg::POS_W'(tcc_pkg::cell_addr(rsp_cursor_line, rsp_cursor_column));

   // stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cell_data) &&
         $stable(rsp_cursor_column) && $stable(rsp_cursor_line) &&
         $stable(rsp_range_error))
      else $error("response word changed while stalled");

   // cursor stays on screen
   a_cursor_on_screen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cursor_column < tcc_pkg::COL_W'(tcc_pkg::COLUMNS)) &&
                    (rsp_cursor_line < tcc_pkg::ROW_W'(tcc_pkg::ROWS)))
      else $error("cursor off screen");

   // linear position agrees with row and column
   a_pos_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_cursor_position == exp_pos)
      else $error("cursor position mismatch");

   // a rejected position never returns cell data
   a_err_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_range_error |-> rsp_cell_data == '0)
      else $error("cell data with range error");

endmodule

bind text_console_cursor_engine tcc_checker u_tcc_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_ch.valid),
   .rsp_ready           (rsp_ch.ready),
   .rsp_cell_data       (rsp_ch.cell_data),
   .rsp_cursor_column   (rsp_ch.cursor_column),
   .rsp_cursor_line     (rsp_ch.cursor_line),
   .rsp_cursor_position (rsp_ch.cursor_position),
   .rsp_range_error     (rsp_ch.range_error)
);

`default_nettype wire
